[src/omni_three_wheel_inverse_kinematics_assert.svh]
// Assertion macros for the three-wheel omni inverse kinematics block.
// Used by the top level only; expects clk_i and rst_ni in scope.
`ifndef OMNI_THREE_WHEEL_INVERSE_KINEMATICS_ASSERT_SVH
`define OMNI_THREE_WHEEL_INVERSE_KINEMATICS_ASSERT_SVH

// Check a property on every clock edge outside reset
`define OTWIK_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Check an implication in the next cycle outside reset
`define OTWIK_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) else $error(msg);

`endif

[src/otwik_pkg.sv]
// Shared types, constants and helper functions for the omni kinematics block.
// No dependencies; used by all modules.
`default_nettype none

package otwik_pkg;

  // Widths of internal datapaths
  localparam int CW = 33;  // CORDIC x, y and angle
  localparam int AW = 35;  // raw angle before wrapping
  localparam int PW = 49;  // trig times velocity product
  localparam int RW = 33;  // distance times yaw rate product
  localparam int NW = 51;  // wheel numerator
  localparam int DW = 38;  // divider dividend and quotient
  localparam int MW = 29;  // magnitude before clamping
  localparam int OW = 18;  // output field width

  localparam int ANGLE_ITER_DEF = 16;

  localparam logic [15:0] RADIUS_RST = 16'd1966;
  localparam logic [15:0] CENTER_RST = 16'd10112;

  localparam logic signed [AW-1:0] PI_Q30      = 35'sd3373259426;
  localparam logic signed [AW-1:0] HALF_PI_Q30 = 35'sd1686629713;
  localparam logic signed [AW-1:0] THIRD_PI_Q30 = 35'sd1124419809;
  localparam logic signed [AW-1:0] TWO_PI_Q30  = 35'sd6746518852;
  localparam logic [CW-1:0] CORDIC_GAIN_Q30 = 33'd652032874;
  localparam logic [21:0] RPM_FACTOR_Q16 = 22'd2503291;

  localparam logic [OW-1:0] OUT_MAX = 18'h1FFFF;
  localparam logic [OW-1:0] OUT_MIN = 18'h20000;

  // Register indexes of the configuration port
  localparam logic REG_RADIUS = 1'b0;
  localparam logic REG_CENTER = 1'b1;

  // Word carried along the CORDIC row, three angles side by side
  typedef struct packed {
    logic [2:0][CW-1:0] x;
    logic [2:0][CW-1:0] y;
    logic [2:0][CW-1:0] a;
    logic [2:0]         neg;
    logic [15:0]        vx;
    logic [15:0]        vy;
    logic [15:0]        yaw;
  } cordic_t;

  // Word carried along the divider row, three wheels side by side
  typedef struct packed {
    logic [2:0][DW-1:0] num;
    logic [2:0][15:0]   rem;
    logic [2:0]         neg;
  } div_t;

  typedef struct packed {
    logic [CW-1:0] a;
    logic          neg;
  } fold_t;

  typedef struct packed {
    logic          sat;
    logic [OW-1:0] val;
  } clamp_t;

  // Arctangent of 2^-i in Q.30
  function automatic logic [CW-1:0] atan_q30(input int i);
    logic [CW-1:0] r;
    case (i)
      0:  r = 33'd843314857;
      1:  r = 33'd497837829;
      2:  r = 33'd263043837;
      3:  r = 33'd133525159;
      4:  r = 33'd67021687;
      5:  r = 33'd33543516;
      6:  r = 33'd16775851;
      7:  r = 33'd8388437;
      8:  r = 33'd4194283;
      9:  r = 33'd2097149;
      10: r = 33'd1048576;
      default: r = (i > 30) ? '0 : CW'(64'd1 << (30 - i));
    endcase
    return r;
  endfunction

  // Wrap once into [-pi, pi], then fold into [-pi/2, pi/2]
  function automatic fold_t wrap_fold(input logic signed [AW-1:0] a_in);
    logic signed [AW-1:0] w;
    fold_t r;
    w = a_in;
    r.neg = 1'b0;
    if (w > PI_Q30) begin
      w = w - TWO_PI_Q30;
    end else if (w < -PI_Q30) begin
      w = w + TWO_PI_Q30;
    end
    if (w > HALF_PI_Q30) begin
      w = w - PI_Q30;
      r.neg = 1'b1;
    end else if (w < -HALF_PI_Q30) begin
      w = w + PI_Q30;
      r.neg = 1'b1;
    end
    r.a = w[CW-1:0];
    return r;
  endfunction

  // Apply sign to a magnitude and clamp to the 18 bit range
  function automatic clamp_t clamp_out(input logic [MW-1:0] mag, input logic neg,
                                       input logic force_sat);
    clamp_t r;
    if (neg) begin
      r.sat = force_sat || (mag > MW'(131072));
      r.val = r.sat ? OUT_MIN : OW'(-mag[OW-1:0]);
    end else begin
      r.sat = force_sat || (mag > MW'(131071));
      r.val = r.sat ? OUT_MAX : mag[OW-1:0];
    end
    return r;
  endfunction

endpackage

`default_nettype wire

[src/otwik_cordic_cell.sv]
// One rotation stage of the CORDIC row, three angles in parallel.
// Depends on otwik_pkg.
`default_nettype none

module otwik_cordic_cell #(
  parameter int STAGE = 0
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              valid_i,
  output logic                   ready_o,
  input  wire otwik_pkg::cordic_t data_i,
  output logic                   valid_o,
  input  wire logic              ready_i,
  output otwik_pkg::cordic_t     data_o
);
  import otwik_pkg::*;

  localparam logic [CW-1:0] ATAN = atan_q30(STAGE);

  cordic_t data_d, data_q;
  logic    valid_q;

  // Rotate each lane toward zero residual angle
  always_comb begin
    logic signed [CW-1:0] x, y, a, dx, dy;
    data_d = data_i;
    for (int k = 0; k < 3; k++) begin
      x  = $signed(data_i.x[k]);
      y  = $signed(data_i.y[k]);
      a  = $signed(data_i.a[k]);
      dx = y >>> STAGE;
      dy = x >>> STAGE;
      if (!a[CW-1]) begin
        data_d.x[k] = x - dx;
        data_d.y[k] = y + dy;
        data_d.a[k] = a - $signed(ATAN);
      end else begin
        data_d.x[k] = x + dx;
        data_d.y[k] = y - dy;
        data_d.a[k] = a + $signed(ATAN);
      end
    end
  end

  assign ready_o = !valid_q || ready_i;

  // Advance the word when the next cell can take it
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      data_q <= data_d;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule

`default_nettype wire

[src/otwik_div_cell.sv]
// One restoring division step of the divider row, three wheels in parallel.
// Depends on otwik_pkg.
`default_nettype none

module otwik_div_cell (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic [15:0]     divisor_i,
  input  wire logic            valid_i,
  output logic                 ready_o,
  input  wire otwik_pkg::div_t data_i,
  output logic                 valid_o,
  input  wire logic            ready_i,
  output otwik_pkg::div_t      data_o
);
  import otwik_pkg::*;

  div_t data_d, data_q;
  logic valid_q;

  // Shift in one dividend bit, subtract when it fits, shift out a quotient bit
  always_comb begin
    logic [16:0] part;
    logic        ge;
    data_d = data_i;
    for (int k = 0; k < 3; k++) begin
      part = {data_i.rem[k], data_i.num[k][DW-1]};
      ge   = part >= {1'b0, divisor_i};
      data_d.rem[k] = ge ? 16'(part - {1'b0, divisor_i}) : part[15:0];
      data_d.num[k] = {data_i.num[k][DW-2:0], ge};
    end
  end

  assign ready_o = !valid_q || ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      data_q <= data_d;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule

`default_nettype wire

[src/omni_three_wheel_inverse_kinematics.sv]
// Throughput: one word per cycle unless m_axis_tready holds the output back; every stage
// advances on its own, so bubbles fill in. The CORDIC row (one cell per iteration) and
// the 38-cell divider row make up most of the pipeline.
// Reset: asynchronous active low, clears all valid bits and loads the default
// wheel radius and center distance; there is no clearing pass.
`default_nettype none

`include "omni_three_wheel_inverse_kinematics_assert.svh"

module omni_three_wheel_inverse_kinematics #(
  parameter int ANGLE_ITERATIONS = otwik_pkg::ANGLE_ITER_DEF
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  // configuration writes
  input  wire logic          cfg_valid_i,
  output logic               cfg_ready_o,
  input  wire logic          cfg_index_i,
  input  wire logic [15:0]   cfg_data_i,
  // input stream
  input  wire logic          s_axis_tvalid,
  output logic               s_axis_tready,
  input  wire logic [63:0]   s_axis_tdata,  // vel_x, vel_y, yaw_rate, heading
  // output stream
  output logic               m_axis_tvalid,
  input  wire logic          m_axis_tready,
  // wheel_rate_a, wheel_rate_b, wheel_rate_c, wheel_rpm_a, wheel_rpm_b, wheel_rpm_c, pad
  output logic [111:0]       m_axis_tdata,
  output logic               m_axis_tuser   // saturated
);
  import otwik_pkg::*;

  typedef struct packed {
    logic [2:0][PW-1:0] px;
    logic [2:0][PW-1:0] py;
    logic [RW-1:0]      rot;
  } prod_t;

  typedef struct packed {
    logic [2:0][NW-1:0] num;
  } sum_t;

  typedef struct packed {
    logic [2:0][MW-1:0]   rm;
    logic [2:0][49:0]     prpm;
    logic [2:0]           big;
    logic [2:0]           neg;
  } post_t;

  typedef struct packed {
    logic [2:0][OW-1:0] rate;
    logic [2:0][OW-1:0] rpm;
    logic               sat;
  } out_t;

  // ---------------- configuration registers ----------------
  logic [15:0] radius_q, center_q;
  logic [15:0] rad;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      radius_q <= RADIUS_RST;
      center_q <= CENTER_RST;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        REG_RADIUS: radius_q <= cfg_data_i;
        REG_CENTER: center_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Treat a zero radius as one
  assign rad = (radius_q == '0) ? 16'd1 : radius_q;

  // ---------------- chains ----------------
  logic    [ANGLE_ITERATIONS:0] cv, cr;
  cordic_t                      cd [ANGLE_ITERATIONS+1];
  logic    [DW:0]               dv, dr;
  div_t                         dd [DW+1];

  logic    v_prod_q, v_sum_q, v_post_q, v_out_q;
  logic    rdy_prod, rdy_sum, rdy_abs, rdy_post, rdy_out;
  prod_t   prod_d, prod_q;
  sum_t    sum_d, sum_q;
  div_t    abs_d;
  logic    v_abs_q;
  div_t    abs_q;
  post_t   post_d, post_q;
  out_t    out_d, out_q;
  cordic_t prep_d, prep_q;
  logic    v_prep_q, rdy_prep;

  // ---------------- angle preparation ----------------
  always_comb begin
    logic signed [AW-1:0] th;
    logic signed [AW-1:0] ang [3];
    fold_t f;
    th = $signed({{2{s_axis_tdata[63]}}, s_axis_tdata[63:48], 17'b0});
    ang[0] = th;
    ang[1] = THIRD_PI_Q30 - th;
    ang[2] = THIRD_PI_Q30 + th;
    prep_d.vx  = s_axis_tdata[15:0];
    prep_d.vy  = s_axis_tdata[31:16];
    prep_d.yaw = s_axis_tdata[47:32];
    for (int k = 0; k < 3; k++) begin
      f = wrap_fold(ang[k]);
      prep_d.a[k]   = f.a;
      prep_d.neg[k] = f.neg;
      prep_d.x[k]   = CORDIC_GAIN_Q30;
      prep_d.y[k]   = '0;
    end
  end

  assign rdy_prep      = !v_prep_q || cr[0];
  assign s_axis_tready = rdy_prep;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_prep_q <= 1'b0;
    end else if (rdy_prep) begin
      v_prep_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy_prep && s_axis_tvalid) begin
      prep_q <= prep_d;
    end
  end

  assign cv[0] = v_prep_q;
  assign cd[0] = prep_q;

  // ---------------- CORDIC row ----------------
  for (genvar i = 0; i < ANGLE_ITERATIONS; i++) begin : g_cordic
    otwik_cordic_cell #(.STAGE(i)) u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .valid_i (cv[i]),
      .ready_o (cr[i]),
      .data_i  (cd[i]),
      .valid_o (cv[i+1]),
      .ready_i (cr[i+1]),
      .data_o  (cd[i+1])
    );
  end

  assign cr[ANGLE_ITERATIONS] = rdy_prod;

  // ---------------- products ----------------
  always_comb begin
    logic signed [CW-1:0] s, c;
    logic signed [PW-1:0] s_w, c_w, vx_w, vy_w;
    logic signed [RW-1:0] ctr_w, yaw_w;
    vx_w = PW'($signed(cd[ANGLE_ITERATIONS].vx));
    vy_w = PW'($signed(cd[ANGLE_ITERATIONS].vy));
    for (int k = 0; k < 3; k++) begin
      s = cd[ANGLE_ITERATIONS].neg[k] ? -$signed(cd[ANGLE_ITERATIONS].y[k])
                                      : $signed(cd[ANGLE_ITERATIONS].y[k]);
      c = cd[ANGLE_ITERATIONS].neg[k] ? -$signed(cd[ANGLE_ITERATIONS].x[k])
                                      : $signed(cd[ANGLE_ITERATIONS].x[k]);
      s_w = PW'(s);
      c_w = PW'(c);
      prod_d.px[k] = s_w * vx_w;
      prod_d.py[k] = c_w * vy_w;
    end
    ctr_w = RW'($signed({1'b0, center_q}));
    yaw_w = RW'($signed(cd[ANGLE_ITERATIONS].yaw));
    prod_d.rot = ctr_w * yaw_w;
  end

  assign rdy_prod = !v_prod_q || rdy_sum;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_prod_q <= 1'b0;
    end else if (rdy_prod) begin
      v_prod_q <= cv[ANGLE_ITERATIONS];
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy_prod && cv[ANGLE_ITERATIONS]) begin
      prod_q <= prod_d;
    end
  end

  // ---------------- matrix row sums ----------------
  always_comb begin
    logic signed [NW-1:0] px [3];
    logic signed [NW-1:0] py [3];
    logic signed [NW-1:0] rot;
    for (int k = 0; k < 3; k++) begin
      px[k] = NW'($signed(prod_q.px[k]));
      py[k] = NW'($signed(prod_q.py[k]));
    end
    rot = NW'($signed(prod_q.rot)) <<< 15;
    sum_d.num[0] = -px[0] + py[0] + rot;
    sum_d.num[1] = -px[1] - py[1] + rot;
    sum_d.num[2] =  px[2] - py[2] + rot;
  end

  assign rdy_sum = !v_sum_q || rdy_abs;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_sum_q <= 1'b0;
    end else if (rdy_sum) begin
      v_sum_q <= v_prod_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy_sum && v_prod_q) begin
      sum_q <= sum_d;
    end
  end

  // ---------------- magnitude, rounding bias, scale by 2^-10 ----------------
  always_comb begin
    logic [NW-1:0] mag, t;
    for (int k = 0; k < 3; k++) begin
      abs_d.neg[k] = sum_q.num[k][NW-1];
      mag = abs_d.neg[k] ? NW'(-$signed(sum_q.num[k])) : sum_q.num[k];
      t   = mag + NW'({rad, 9'b0});
      abs_d.num[k] = t[DW+9:10];
      abs_d.rem[k] = '0;
    end
  end

  assign rdy_abs = !v_abs_q || dr[0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_abs_q <= 1'b0;
    end else if (rdy_abs) begin
      v_abs_q <= v_sum_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy_abs && v_sum_q) begin
      abs_q <= abs_d;
    end
  end

  assign dv[0] = v_abs_q;
  assign dd[0] = abs_q;

  // ---------------- divider row ----------------
  for (genvar j = 0; j < DW; j++) begin : g_div
    otwik_div_cell u_cell (
      .clk_i     (clk_i),
      .rst_ni    (rst_ni),
      .divisor_i (rad),
      .valid_i   (dv[j]),
      .ready_o   (dr[j]),
      .data_i    (dd[j]),
      .valid_o   (dv[j+1]),
      .ready_i   (dr[j+1]),
      .data_o    (dd[j+1])
    );
  end

  assign dr[DW] = rdy_post;

  // ---------------- rate rounding and rpm product ----------------
  always_comb begin
    logic [DW-1:0] q;
    logic [DW:0]   r;
    for (int k = 0; k < 3; k++) begin
      q = dd[DW].num[k];
      r = {1'b0, q} + (DW+1)'(512);
      post_d.rm[k]   = r[DW:10];
      post_d.big[k]  = |q[DW-1:28];
      post_d.prpm[k] = 50'(q[27:0]) * 50'(RPM_FACTOR_Q16);
      post_d.neg[k]  = dd[DW].neg[k];
    end
  end

  assign rdy_post = !v_post_q || rdy_out;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_post_q <= 1'b0;
    end else if (rdy_post) begin
      v_post_q <= dv[DW];
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy_post && dv[DW]) begin
      post_q <= post_d;
    end
  end

  // ---------------- clamp into the output register ----------------
  always_comb begin
    logic [50:0] pr;
    clamp_t cr_rate, cr_rpm;
    out_d.sat = 1'b0;
    for (int k = 0; k < 3; k++) begin
      pr = {1'b0, post_q.prpm[k]} + 51'(64'h8000_0000);
      cr_rate = clamp_out(post_q.rm[k], post_q.neg[k], 1'b0);
      cr_rpm  = clamp_out(MW'(pr[50:32]), post_q.neg[k], post_q.big[k]);
      out_d.rate[k] = cr_rate.val;
      out_d.rpm[k]  = cr_rpm.val;
      out_d.sat     = out_d.sat | cr_rate.sat | cr_rpm.sat;
    end
  end

  assign rdy_out = !v_out_q || m_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_out_q <= 1'b0;
    end else if (rdy_out) begin
      v_out_q <= v_post_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy_out && v_post_q) begin
      out_q <= out_d;
    end
  end

  assign m_axis_tvalid = v_out_q;
  assign m_axis_tdata  = {4'b0, out_q.rpm[2], out_q.rpm[1], out_q.rpm[0],
                          out_q.rate[2], out_q.rate[1], out_q.rate[0]};
  assign m_axis_tuser  = out_q.sat;

  // ---------------- assertions ----------------
  `OTWIK_ASSERT(a_sat_has_clamp,
    !(v_out_q && out_q.sat) ||
    out_q.rate[0] == OUT_MAX || out_q.rate[0] == OUT_MIN ||
    out_q.rate[1] == OUT_MAX || out_q.rate[1] == OUT_MIN ||
    out_q.rate[2] == OUT_MAX || out_q.rate[2] == OUT_MIN ||
    out_q.rpm[0] == OUT_MAX || out_q.rpm[0] == OUT_MIN ||
    out_q.rpm[1] == OUT_MAX || out_q.rpm[1] == OUT_MIN ||
    out_q.rpm[2] == OUT_MAX || out_q.rpm[2] == OUT_MIN,
    "saturated flag set without a clamped value")
  `OTWIK_ASSERT(a_empty_out_accepts, v_out_q || s_axis_tready,
    "input stalled while the output register is empty")
  `OTWIK_ASSERT_NEXT(a_accept_enters, s_axis_tvalid && s_axis_tready, v_prep_q,
    "accepted word did not enter the first stage")

endmodule

`default_nettype wire

[tb/omni_three_wheel_inverse_kinematics_tb.sv]
// Testbench for the three-wheel omni inverse kinematics block.
// Predicts wheel rates and rpm per command word and checks the output stream.
// Depends on otwik_pkg and the omni_three_wheel_inverse_kinematics top level.
`timescale 1ns / 1ps

module omni_three_wheel_inverse_kinematics_tb;
  import otwik_pkg::*;

  localparam int ITERS = ANGLE_ITER_DEF;
  localparam int DRAIN_CYCLES = ITERS + 44 + 20;
  localparam longint ANG_PI = 64'sd3373259426;
  localparam longint ANG_HALF_PI = 64'sd1686629713;
  localparam longint ANG_THIRD_PI = 64'sd1124419809;
  localparam longint ANG_TWO_PI = 64'sd6746518852;
  localparam longint GAIN = 64'sd652032874;
  localparam longint RPM_K = 64'sd2503291;
  localparam longint LIM_HI = 64'sd131071;
  localparam longint LIM_LO = -64'sd131072;

  typedef struct packed {
    logic [17:0] rate_a, rate_b, rate_c;
    logic [17:0] rpm_a, rpm_b, rpm_c;
    logic        sat;
  } wheel_word_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_valid_i = 1'b0;
  logic cfg_ready_o;
  logic cfg_index_i = REG_RADIUS;
  logic [15:0] cfg_data_i = '0;
  logic s_axis_tvalid = 1'b0;
  logic s_axis_tready;
  logic [63:0] s_axis_tdata = '0;
  logic m_axis_tvalid;
  logic m_axis_tready = 1'b0;
  logic [111:0] m_axis_tdata;
  logic m_axis_tuser;

  omni_three_wheel_inverse_kinematics dut (
    .clk_i, .rst_ni, .cfg_valid_i, .cfg_ready_o, .cfg_index_i, .cfg_data_i,
    .s_axis_tvalid, .s_axis_tready, .s_axis_tdata,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .m_axis_tuser
  );

  // Predictor copy of the registers
  longint radius_q16 = 1966;
  longint center_q16 = 10112;

  wheel_word_t expected_wheels[$];
  int unsigned mismatch_count = 0;
  int unsigned checked_count = 0;
  int unsigned sat_seen = 0;
  int send_idle_pct = 0;
  int recv_stall_pct = 0;

  initial begin
    forever #10 clk_i = ~clk_i;
  end

  initial begin
    #400ms;
    $display("Timeout with %0d words outstanding", expected_wheels.size());
    $display("== FAIL ==");
    $finish;
  end

  // Floor shift right
  function automatic longint shr_floor(longint v, int s);
    if (s > 62) return (v < 0) ? -1 : 0;
    return v >>> s;
  endfunction

  function automatic longint atan_angle(int i);
    longint tbl[11] = '{843314857, 497837829, 263043837, 133525159, 67021687,
                        33543516, 16775851, 8388437, 4194283, 2097149, 1048576};
    if (i < 11) return tbl[i];
    if (i > 30) return 0;
    return longint'(1) << (30 - i);
  endfunction

  // Rotation CORDIC after one wrap and a fold into the right half plane
  task automatic cordic_sincos(input longint ang, output longint sn, output longint cs);
    longint a, x, y, dx, dy;
    bit flip;
    a = ang; x = GAIN; y = 0; flip = 0;
    if (a > ANG_PI) a -= ANG_TWO_PI;
    else if (a < -ANG_PI) a += ANG_TWO_PI;
    if (a > ANG_HALF_PI) begin
      a -= ANG_PI; flip = 1;
    end else if (a < -ANG_HALF_PI) begin
      a += ANG_PI; flip = 1;
    end
    for (int i = 0; i < ITERS; i++) begin
      dx = shr_floor(y, i);
      dy = shr_floor(x, i);
      if (a >= 0) begin
        x -= dx; y += dy; a -= atan_angle(i);
      end else begin
        x += dx; y -= dy; a += atan_angle(i);
      end
    end
    sn = flip ? -y : y;
    cs = flip ? -x : x;
  endtask

  function automatic longint round_div(longint num, longint den);
    if (num >= 0) return (num + den / 2) / den;
    return -((-num + den / 2) / den);
  endfunction

  function automatic logic [17:0] clip18(longint v, ref bit sat);
    if (v > LIM_HI) begin
      sat = 1; return 18'(LIM_HI);
    end
    if (v < LIM_LO) begin
      sat = 1; return 18'(LIM_LO);
    end
    return 18'(v);
  endfunction

  // 128-bit product to keep w * RPM_K exact
  function automatic longint rpm_of(longint w);
    logic signed [127:0] p, r;
    p = 128'(w) * 128'(RPM_K);
    if (p >= 0) r = (p + (128'sd1 <<< 31)) >>> 32;
    else r = -((-p + (128'sd1 <<< 31)) >>> 32);
    return longint'(r);
  endfunction

  task automatic predict_wheels(input logic [63:0] cmd, output wheel_word_t res);
    longint vx, vy, yaw, th, den, rot, s0, c0, s1, c1, s2, c2, w;
    longint num[3];
    logic [17:0] rates[3], rpms[3];
    bit sat;
    vx = longint'($signed(cmd[15:0]));
    vy = longint'($signed(cmd[31:16]));
    yaw = longint'($signed(cmd[47:32]));
    th = longint'($signed(cmd[63:48])) * 131072;
    den = ((radius_q16 == 0) ? 1 : radius_q16) * 1024;
    rot = center_q16 * yaw * 32768;
    sat = 0;
    cordic_sincos(th, s0, c0);
    cordic_sincos(ANG_THIRD_PI - th, s1, c1);
    cordic_sincos(ANG_THIRD_PI + th, s2, c2);
    num[0] = -s0 * vx + c0 * vy + rot;
    num[1] = -s1 * vx - c1 * vy + rot;
    num[2] = s2 * vx - c2 * vy + rot;
    for (int k = 0; k < 3; k++) begin
      w = round_div(num[k], den);
      rates[k] = clip18(round_div(w, 1024), sat);
      rpms[k] = clip18(rpm_of(w), sat);
    end
    res = '{rates[0], rates[1], rates[2], rpms[0], rpms[1], rpms[2], sat};
  endtask

  // Send one command word, idling before it at the current rate
  task automatic send_cmd(input logic [15:0] vx, input logic [15:0] vy,
                          input logic [15:0] yaw, input logic [15:0] hd);
    wheel_word_t res;
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= {hd, yaw, vy, vx};
    predict_wheels({hd, yaw, vy, vx}, res);
    expected_wheels.push_back(res);
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
  endtask

  task automatic go_idle();
    s_axis_tvalid <= 1'b0;
  endtask

  // Wait out the pipeline before touching a register
  task automatic drain();
    int n;
    go_idle();
    n = 0;
    while (expected_wheels.size() != 0 && n < 2000000) begin
      @(posedge clk_i); n++;
    end
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  // Hold valid through the write; the caller drops it after the last one
  task automatic write_reg(input logic idx, input logic [15:0] val);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    if (idx == REG_RADIUS) radius_q16 = val;
    else center_q16 = val;
  endtask

  // Receiver: random stall, check each accepted word against the oldest prediction
  always @(posedge clk_i) begin
    wheel_word_t got, exp_w;
    if (rst_ni) begin
      if (m_axis_tvalid && m_axis_tready) begin
        got = '{m_axis_tdata[17:0], m_axis_tdata[35:18], m_axis_tdata[53:36],
                m_axis_tdata[71:54], m_axis_tdata[89:72], m_axis_tdata[107:90],
                m_axis_tuser};
        if (expected_wheels.size() == 0) begin
          mismatch_count++;
          if (mismatch_count <= 10) $display("Unexpected output word %h", got);
        end else begin
          exp_w = expected_wheels.pop_front();
          checked_count++;
          if (exp_w.sat) sat_seen++;
          if (got !== exp_w) begin
            mismatch_count++;
            if (mismatch_count <= 10) begin
              $display("Mismatch: exp rate %0d %0d %0d rpm %0d %0d %0d sat %b",
                $signed(exp_w.rate_a), $signed(exp_w.rate_b), $signed(exp_w.rate_c),
                $signed(exp_w.rpm_a), $signed(exp_w.rpm_b), $signed(exp_w.rpm_c),
                exp_w.sat);
              $display("          got rate %0d %0d %0d rpm %0d %0d %0d sat %b",
                $signed(got.rate_a), $signed(got.rate_b), $signed(got.rate_c),
                $signed(got.rpm_a), $signed(got.rpm_b), $signed(got.rpm_c), got.sat);
            end
          end
        end
      end
      m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  function automatic logic [15:0] rand_heading();
    return 16'($signed($urandom_range(51472)) - 25736);
  endfunction

  // Velocity mostly moderate, sometimes full scale
  function automatic logic [15:0] rand_vel();
    if ($urandom_range(3) == 0) return 16'($urandom);
    return 16'($signed($urandom_range(4096)) - 2048);
  endfunction

  task automatic test_directed_extremes();
    logic [15:0] hds[9] = '{16'd0, 16'd25736, -16'sd25736, 16'd12868, -16'sd12868,
                            16'h7FFF, 16'h8000, 16'd8579, 16'hFFFF};
    foreach (hds[i]) send_cmd(16'd4096, 16'd0, 16'd0, hds[i]);
    send_cmd(16'h7FFF, 16'h7FFF, 16'h7FFF, 16'd0);
    send_cmd(16'h8000, 16'h8000, 16'h8000, 16'd0);
    send_cmd(16'h7FFF, 16'h8000, 16'h7FFF, 16'h8000);
    send_cmd(16'd0, 16'd0, 16'd0, 16'd0);
    send_cmd(16'd0, 16'd0, 16'd2048, 16'd0);
    send_cmd(16'd0, 16'hF000, 16'hF800, 16'd1000);
    send_cmd(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    send_cmd(16'h5555, 16'hAAAA, 16'h5555, 16'h2AAA);
    send_cmd(16'hAAAA, 16'h5555, 16'hAAAA, 16'hD555);
    drain();
  endtask

  task automatic test_random_phase(int count, int idle, int stall);
    send_idle_pct = idle;
    recv_stall_pct = stall;
    for (int i = 0; i < count; i++) begin
      // Long stretches without idling mixed in
      if (i % 100 == 50) send_idle_pct = 0;
      if (i % 100 == 80) send_idle_pct = idle;
      send_cmd(rand_vel(), rand_vel(), rand_vel(),
               ($urandom_range(9) == 0) ? 16'($urandom) : rand_heading());
    end
    drain();
  endtask

  task automatic test_config(input logic [15:0] rad, input logic [15:0] ctr);
    write_reg(REG_RADIUS, rad);
    write_reg(REG_CENTER, ctr);
    cfg_valid_i <= 1'b0;
    @(posedge clk_i);
  endtask

  initial begin
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed_extremes();
    test_random_phase(430, 0, 0);
    test_config(16'd0, 16'd0);
    test_random_phase(150, 58, 0);
    test_config(16'd1, 16'hFFFF);
    test_random_phase(150, 0, 58);
    test_config(16'hFFFF, 16'd0);
    test_random_phase(150, 37, 37);
    test_config(16'h5555, 16'hAAAA);
    test_random_phase(150, 58, 58);
    test_config(16'd1966, 16'd10112);
    test_random_phase(250, 0, 58);
    test_config(16'd3000, 16'd20000);
    test_random_phase(250, 58, 0);
    test_config(16'd800, 16'd5000);
    test_random_phase(300, 37, 37);
    recv_stall_pct = 0;
    $display("Checked %0d wheel words over seven register settings, %0d saturated",
             checked_count, sat_seen);
    if (mismatch_count == 0 && expected_wheels.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("%0d mismatches, %0d words missing", mismatch_count, expected_wheels.size());
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
